/* rtl/core/sscm_pkg.sv */
// ----------------------------------------------------------------------------
// sscm_pkg
// Shared types, constants and the segment decode for the seven-segment
// counter multiplexer.
// ----------------------------------------------------------------------------
package sscm_pkg;

  // Default number of displayed digits
  localparam int DIGITS_DEF = 4;

  // Register reset values
  localparam logic [15:0] MASK_RESET  = 16'h01ff;
  localparam logic [15:0] START_RESET = 16'd1800;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 1'b1;

  // Queue depth between front and back
  localparam int QDEPTH = 2;

  // Divide by ten: q = (x * 52429) >> 19, exact for any 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // One queued scan tick
  typedef struct packed {
    logic        refresh;  // convert value and latch new patterns
    logic        tick;     // advance digit select
    logic        wrap;     // tick count rolls over, digit select restarts
    logic [15:0] value;    // counter value to convert
  } item_t;

  // Decimal digit to segments, bit0 = a .. bit6 = g
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/sscm_front.sv */
// ----------------------------------------------------------------------------
// sscm_front
// Accepts scan ticks, keeps the tick count, update mask and counter, and
// classifies each tick into a queue entry for the back end.
// ----------------------------------------------------------------------------
module sscm_front import sscm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_tick,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic [15:0] tick_count_r, tick_count_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [15:0] counter_r, counter_nxt;
  logic        refresh;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the tick
  assign refresh = in_tick && ((tick_count_r & mask_r) == 16'd0);

  always_comb begin
    q_item.refresh = refresh;
    q_item.tick    = in_tick;
    q_item.wrap    = in_tick && (tick_count_r == 16'hffff);
    q_item.value   = counter_r;
  end

  // Next state for count, mask and counter; user does config writes only when idle (block does not enforce)
  always_comb begin
    tick_count_nxt = tick_count_r;
    mask_nxt       = mask_r;
    counter_nxt    = counter_r;
    if (q_push && in_tick) begin
      tick_count_nxt = tick_count_r + 16'd1;
    end
    if (q_push && refresh) begin
      counter_nxt = counter_r + 16'd1;
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_UPDATE_MASK: mask_nxt    = cfg_data;
        CFG_START_VALUE: counter_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= 16'd0;
      mask_r       <= MASK_RESET;
      counter_r    <= START_RESET;
    end else begin
      tick_count_r <= tick_count_nxt;
      mask_r       <= mask_nxt;
      counter_r    <= counter_nxt;
    end
  end

endmodule

/* rtl/core/sscm_fifo.sv */
// ----------------------------------------------------------------------------
// sscm_fifo
// Short queue between the front and the back end.
// ----------------------------------------------------------------------------
module sscm_fifo import sscm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_data,
  input  logic  pop,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/sscm_back.sv */
// ----------------------------------------------------------------------------
// sscm_back
// Digit pipeline: one divide-by-ten per stage, then the pattern store,
// digit select counter and output register.
// ----------------------------------------------------------------------------
module sscm_back import sscm_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_digit_select,
  output logic [7:0]  out_segments,
  output logic [15:0] out_shown_value
);

  localparam int SEL_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef logic [DIGITS-1:0][6:0] pat_vec_t;

  // Pipeline stage registers, stage k holds digits below k
  logic        st_valid_r [DIGITS+1];
  item_t       st_item_r  [DIGITS+1];
  logic [15:0] st_rest_r  [DIGITS+1];
  pat_vec_t    st_pat_r   [DIGITS+1];

  // Per-stage divide results
  logic [32:0] prod    [DIGITS];
  logic [15:0] quot    [DIGITS];
  logic [3:0]  dig     [DIGITS];
  pat_vec_t    pat_nxt [DIGITS];

  // Display state
  pat_vec_t         pat_store_r;
  logic [15:0]      disp_r;
  logic [SEL_W-1:0] sel_r, sel_nxt;

  // Output register
  logic             out_valid_r;
  logic [1:0]       out_sel_r;
  logic [6:0]       out_seg_r;
  logic [15:0]      out_shown_r;

  logic             en;
  logic             fin_fire;
  item_t            fin;
  pat_vec_t         cur_pat;
  logic [15:0]      cur_disp;

  // Whole back end advances unless a held result is stalled
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  // One decimal digit per stage
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      prod[k]    = st_rest_r[k] * DIV10_MUL;
      quot[k]    = 16'(prod[k] >> DIV10_SHIFT);
      dig[k]     = 4'(st_rest_r[k] - ((quot[k] << 3) + (quot[k] << 1)));
      pat_nxt[k] = st_pat_r[k];
      // leading zero blanks
      pat_nxt[k][k] = (dig[k] == 4'd0 && quot[k] == 16'd0) ? 7'h00 : seg_of(dig[k]);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIGITS; k++) begin
        st_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      st_valid_r[0] <= !q_empty;
      for (int k = 0; k < DIGITS; k++) begin
        st_valid_r[k+1] <= st_valid_r[k];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_item_r[0] <= q_data;
      st_rest_r[0] <= q_data.value;
      st_pat_r[0]  <= '0;
      for (int k = 0; k < DIGITS; k++) begin
        st_item_r[k+1] <= st_item_r[k];
        st_rest_r[k+1] <= quot[k];
        st_pat_r[k+1]  <= pat_nxt[k];
      end
    end
  end

  // Final stage: apply refresh, pick the active digit
  assign fin      = st_item_r[DIGITS];
  assign fin_fire = en && st_valid_r[DIGITS];
  assign cur_pat  = fin.refresh ? st_pat_r[DIGITS] : pat_store_r;
  assign cur_disp = fin.refresh ? fin.value : disp_r;

  always_comb begin
    sel_nxt = sel_r;
    if (fin.wrap) begin
      sel_nxt = '0;
    end else if (fin.tick) begin
      sel_nxt = (sel_r == SEL_W'(DIGITS - 1)) ? '0 : sel_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_store_r <= '0;
      disp_r      <= 16'd0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        out_valid_r <= st_valid_r[DIGITS];
      end
      if (fin_fire) begin
        pat_store_r <= cur_pat;
        disp_r      <= cur_disp;
        sel_r       <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_sel_r   <= 2'(sel_r);
      out_seg_r   <= cur_pat[sel_r];
      out_shown_r <= cur_disp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = out_sel_r;
  assign out_segments     = {1'b0, out_seg_r};
  assign out_shown_value  = out_shown_r;

endmodule

/* rtl/core/seven_segment_counter_mux_core.sv */
// ----------------------------------------------------------------------------
// seven_segment_counter_mux_core
// Multiplexed decimal seven-segment counter driver.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel is one scan tick (in_tick). Every tick
// gives one transfer on the out_ channel: the active digit index, its
// segment pattern (bit0 = a .. bit6 = g, point always off) and the value
// shown. When the tick count ANDed with update_mask is zero, the counter
// value is converted to decimal with leading zeros blanked, latched for
// display and then incremented.
// From input transfer to output valid, a tick passes through the queue,
// then the digit pipeline with one divide-by-ten stage per digit, then
// the output register. Throughput is one tick per cycle while out_stall is low.
// A two-entry queue sits between the front and the digit pipeline, so
// in_stall rises only once the queue fills while out_stall holds the
// back end; a stalled result holds its value.
// Reset clears the tick count, patterns and shown value, loads the
// counter with 1800 and the mask with 0x1ff. Writing start_value loads
// the counter at once.
// ----------------------------------------------------------------------------
module seven_segment_counter_mux_core import sscm_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_digit_select,
  output logic [7:0]           out_segments,
  output logic [15:0]          out_shown_value,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_wr_item, q_rd_item;

  // Front: accept and classify
  sscm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_tick   (in_tick),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  // Queue
  sscm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_item),
    .pop     (q_pop),
    .rd_data (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: digit conversion and display
  sscm_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rd_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_select (out_digit_select),
    .out_segments     (out_segments),
    .out_shown_value  (out_shown_value)
  );

endmodule

/* rtl/core/sscm_checker.sv */
// ----------------------------------------------------------------------------
// sscm_checker
// Port-level checks for the seven-segment counter multiplexer.
// ----------------------------------------------------------------------------
module sscm_checker import sscm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_tick,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_digit_select,
  input logic [7:0]           out_segments,
  input logic [15:0]          out_shown_value
);

  // A stalled tick stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_tick))
    else $error("stalled tick changed or dropped");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Decimal point is never lit
  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_segments[7])
    else $error("decimal point lit");

  // A shown value of zero is fully blank
  a_zero_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_shown_value == 16'd0) |-> (out_segments == 8'd0))
    else $error("zero value not blank");

  // No output appears in the cycle right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind seven_segment_counter_mux_core sscm_checker u_sscm_checker (.*);
